/* hdl/tvsp_pkg.sv */
// Shared types and constants for the tagged value stream parser.
package tvsp_pkg;

  localparam int unsigned LenBits  = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned TagW     = 8;

  localparam logic [TagW-1:0] RstTagNull    = 8'd0;
  localparam logic [TagW-1:0] RstTagPosInt  = 8'd1;
  localparam logic [TagW-1:0] RstTagNegInt  = 8'd2;
  localparam logic [TagW-1:0] RstTagFalse   = 8'd3;
  localparam logic [TagW-1:0] RstTagTrue    = 8'd4;
  localparam logic [TagW-1:0] RstTagDouble  = 8'd5;
  localparam logic [TagW-1:0] RstTagString  = 8'd6;

  localparam logic [3:0] VarintLastIdx   = 4'd8;
  localparam logic [5:0] VarintShiftStep = 6'd7;
  localparam logic [7:0] VarintPayload   = 8'h7F;
  localparam logic [2:0] DblLastByte     = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TAG_NULL    = 3'd0,
    CFG_TAG_POS_INT = 3'd1,
    CFG_TAG_NEG_INT = 3'd2,
    CFG_TAG_FALSE   = 3'd3,
    CFG_TAG_TRUE    = 3'd4,
    CFG_TAG_DOUBLE  = 3'd5,
    CFG_TAG_STRING  = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_TAG   = 5'b00001,
    PH_INT   = 5'b00010,
    PH_DBL   = 5'b00100,
    PH_SLEN  = 5'b01000,
    PH_SBYTE = 5'b10000
  } phase_e;

  typedef enum logic [3:0] {
    KIND_NULL       = 4'd0,
    KIND_INT        = 4'd1,
    KIND_BOOL       = 4'd2,
    KIND_DOUBLE     = 4'd3,
    KIND_SHEAD      = 4'd4,
    KIND_SBYTE      = 4'd5,
    KIND_BAD_TAG    = 4'd6,
    KIND_LONG       = 4'd7,
    KIND_LARGE      = 4'd8,
    KIND_INCOMPLETE = 4'd9
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } tvsp_in_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [63:0] value;
    logic               last_of_value;
    logic [31:0]        consumed_bytes;
  } tvsp_out_t;

  typedef struct packed {
    logic [TagW-1:0] tag_null;
    logic [TagW-1:0] tag_positive_int;
    logic [TagW-1:0] tag_negative_int;
    logic [TagW-1:0] tag_bool_false;
    logic [TagW-1:0] tag_bool_true;
    logic [TagW-1:0] tag_double;
    logic [TagW-1:0] tag_string;
  } tvsp_tags_t;

  typedef struct packed {
    phase_e             phase;
    logic [63:0]        acc;
    logic [3:0]         vidx;
    logic               neg;
    logic [2:0]         dbc;
    logic [LenBits-1:0] srem;
    logic [31:0]        bcnt;
    logic               drop;
  } tvsp_state_t;

endpackage

/* hdl/tvsp_step.sv */
// Per-word decode: next parser state and the optional result from the current word.
module tvsp_step import tvsp_pkg::*; (
  input  tvsp_state_t st_q_i,
  input  tvsp_tags_t  tags_i,
  input  tvsp_in_t    word_i,
  output tvsp_state_t st_d_o,
  output logic        res_vld_o,
  output tvsp_out_t   res_o
);

  logic [7:0]         b;
  logic               eob;
  logic [3:0]         idx_cap;
  logic [5:0]         shamt;
  logic [63:0]        vacc;
  logic [3:0]         vidx_new;
  logic               vdone;
  logic               vlong;
  logic [31:0]        bc_inc;
  logic [63:0]        dacc;
  logic [LenBits-1:0] srem_dec;

  assign b   = word_i.data_byte;
  assign eob = word_i.end_of_buffer;

  assign idx_cap  = (st_q_i.vidx > VarintLastIdx) ? VarintLastIdx : st_q_i.vidx;
  assign shamt    = 6'(idx_cap) * VarintShiftStep;
  assign vacc     = st_q_i.acc | ({56'd0, b & VarintPayload} << shamt);
  assign vidx_new = idx_cap + 4'd1;
  assign vdone    = !b[7];
  assign vlong    = vidx_new > VarintLastIdx;
  assign bc_inc   = (&st_q_i.bcnt) ? st_q_i.bcnt : st_q_i.bcnt + 32'd1;
  assign dacc     = {st_q_i.acc[55:0], b};
  assign srem_dec = (st_q_i.srem != '0) ? st_q_i.srem - LenBits'(1) : st_q_i.srem;

  always_comb begin
    st_d_o    = st_q_i;
    res_vld_o = 1'b0;
    res_o     = '0;
    res_o.consumed_bytes = (st_q_i.phase == PH_TAG) ? 32'd1 : bc_inc;
    if (st_q_i.drop) begin
      if (eob) begin
        st_d_o.drop  = 1'b0;
        st_d_o.phase = PH_TAG;
      end
    end else begin
      case (st_q_i.phase)
        PH_TAG: begin
          st_d_o.bcnt = 32'd1;
          st_d_o.acc  = '0;
          st_d_o.vidx = '0;
          st_d_o.dbc  = '0;
          st_d_o.srem = '0;
          st_d_o.neg  = 1'b0;
          res_o.last_of_value = 1'b1;
          if (b == tags_i.tag_null) begin
            res_vld_o  = 1'b1;
            res_o.kind = KIND_NULL;
          end else if (b == tags_i.tag_positive_int || b == tags_i.tag_negative_int) begin
            st_d_o.neg = (b != tags_i.tag_positive_int);
            if (eob) begin
              res_vld_o  = 1'b1;
              res_o.kind = KIND_INCOMPLETE;
            end else begin
              st_d_o.phase = PH_INT;
            end
          end else if (b == tags_i.tag_bool_false) begin
            res_vld_o  = 1'b1;
            res_o.kind = KIND_BOOL;
          end else if (b == tags_i.tag_bool_true) begin
            res_vld_o   = 1'b1;
            res_o.kind  = KIND_BOOL;
            res_o.value = 64'sd1;
          end else if (b == tags_i.tag_double || b == tags_i.tag_string) begin
            if (eob) begin
              res_vld_o  = 1'b1;
              res_o.kind = KIND_INCOMPLETE;
            end else begin
              st_d_o.phase = (b == tags_i.tag_double) ? PH_DBL : PH_SLEN;
            end
          end else begin
            res_vld_o   = 1'b1;
            res_o.kind  = KIND_BAD_TAG;
            res_o.value = signed'({56'd0, b});
            st_d_o.drop = !eob;
          end
        end
        PH_INT: begin
          st_d_o.bcnt = bc_inc;
          st_d_o.acc  = vacc;
          st_d_o.vidx = vidx_new;
          res_o.last_of_value = 1'b1;
          if (vdone) begin
            res_vld_o    = 1'b1;
            res_o.kind   = KIND_INT;
            res_o.value  = signed'(st_q_i.neg ? 64'd0 - vacc : vacc);
            st_d_o.phase = PH_TAG;
          end else if (eob) begin
            res_vld_o    = 1'b1;
            res_o.kind   = KIND_INCOMPLETE;
            st_d_o.phase = PH_TAG;
          end else if (vlong) begin
            res_vld_o    = 1'b1;
            res_o.kind   = KIND_LONG;
            st_d_o.phase = PH_TAG;
            st_d_o.drop  = 1'b1;
          end
        end
        PH_DBL: begin
          st_d_o.bcnt = bc_inc;
          st_d_o.acc  = dacc;
          res_o.last_of_value = 1'b1;
          if (st_q_i.dbc >= DblLastByte) begin
            res_vld_o    = 1'b1;
            res_o.kind   = KIND_DOUBLE;
            res_o.value  = signed'(dacc);
            st_d_o.phase = PH_TAG;
          end else begin
            st_d_o.dbc = st_q_i.dbc + 3'd1;
            if (eob) begin
              res_vld_o    = 1'b1;
              res_o.kind   = KIND_INCOMPLETE;
              st_d_o.phase = PH_TAG;
            end
          end
        end
        PH_SLEN: begin
          st_d_o.bcnt = bc_inc;
          st_d_o.acc  = vacc;
          st_d_o.vidx = vidx_new;
          res_o.last_of_value = 1'b1;
          if (!vdone) begin
            if (eob) begin
              res_vld_o    = 1'b1;
              res_o.kind   = KIND_INCOMPLETE;
              st_d_o.phase = PH_TAG;
            end else if (vlong) begin
              res_vld_o    = 1'b1;
              res_o.kind   = KIND_LONG;
              st_d_o.phase = PH_TAG;
              st_d_o.drop  = 1'b1;
            end
          end else if (|vacc[63:LenBits]) begin
            res_vld_o    = 1'b1;
            res_o.kind   = KIND_LARGE;
            res_o.value  = signed'(vacc);
            st_d_o.phase = PH_TAG;
            st_d_o.drop  = !eob;
          end else if (vacc == 64'd0) begin
            res_vld_o    = 1'b1;
            res_o.kind   = KIND_SHEAD;
            st_d_o.phase = PH_TAG;
          end else if (eob) begin
            res_vld_o    = 1'b1;
            res_o.kind   = KIND_INCOMPLETE;
            st_d_o.phase = PH_TAG;
          end else begin
            res_vld_o           = 1'b1;
            res_o.kind          = KIND_SHEAD;
            res_o.value         = signed'(vacc);
            res_o.last_of_value = 1'b0;
            st_d_o.srem         = vacc[LenBits-1:0];
            st_d_o.phase        = PH_SBYTE;
          end
        end
        PH_SBYTE: begin
          st_d_o.bcnt = bc_inc;
          st_d_o.srem = srem_dec;
          res_vld_o   = 1'b1;
          if (srem_dec == '0) begin
            res_o.kind          = KIND_SBYTE;
            res_o.value         = signed'({56'd0, b});
            res_o.last_of_value = 1'b1;
            st_d_o.phase        = PH_TAG;
          end else if (eob) begin
            res_o.kind          = KIND_INCOMPLETE;
            res_o.last_of_value = 1'b1;
            st_d_o.phase        = PH_TAG;
          end else begin
            res_o.kind  = KIND_SBYTE;
            res_o.value = signed'({56'd0, b});
          end
        end
        default: begin
          st_d_o.phase = PH_TAG;
        end
      endcase
    end
  end

endmodule

/* hdl/tagged_value_stream_parser.sv */
// Top level of the tagged value stream parser: input register, decode step, result register.
//
// Decodes one input word (one byte of the buffer) per cycle while the output is not stalled.
// Each accepted word is registered in the input register, decoded against the parser
// state in one step, and the result (if any) is held in the output register. Tags, varints,
// doubles and string headers give one result at their final byte; strings give one result per
// byte. The input side stalls only when a word is held and the result register cannot drain.
module tagged_value_stream_parser import tvsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tvsp_in_t           in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tvsp_out_t          out_word_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TagW-1:0]    cfg_data_i
);

  tvsp_in_t    in_q;
  logic        in_vld_q;
  tvsp_state_t st_q;
  tvsp_state_t st_d;
  tvsp_tags_t  tags_q;
  tvsp_out_t   out_q;
  logic        out_vld_q;
  logic        res_vld;
  tvsp_out_t   res;
  logic        advance;

  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !advance;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  tvsp_step u_step (
    .st_q_i    (st_q),
    .tags_i    (tags_q),
    .word_i    (in_q),
    .st_d_o    (st_d),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{phase: PH_TAG, default: '0};
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance && res_vld) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tags_q.tag_null         <= RstTagNull;
      tags_q.tag_positive_int <= RstTagPosInt;
      tags_q.tag_negative_int <= RstTagNegInt;
      tags_q.tag_bool_false   <= RstTagFalse;
      tags_q.tag_bool_true    <= RstTagTrue;
      tags_q.tag_double       <= RstTagDouble;
      tags_q.tag_string       <= RstTagString;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TAG_NULL:    tags_q.tag_null         <= cfg_data_i;
        CFG_TAG_POS_INT: tags_q.tag_positive_int <= cfg_data_i;
        CFG_TAG_NEG_INT: tags_q.tag_negative_int <= cfg_data_i;
        CFG_TAG_FALSE:   tags_q.tag_bool_false   <= cfg_data_i;
        CFG_TAG_TRUE:    tags_q.tag_bool_true    <= cfg_data_i;
        CFG_TAG_DOUBLE:  tags_q.tag_double       <= cfg_data_i;
        CFG_TAG_STRING:  tags_q.tag_string       <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/tvsp_checker.sv */
// Port-level checks for the tagged value stream parser and their bind.
module tvsp_checker import tvsp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input tvsp_out_t out_word_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // the input side stalls only behind a blocked result word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result word");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_BAD_TAG || out_word_o.kind == KIND_LONG ||
                    out_word_o.kind == KIND_LARGE || out_word_o.kind == KIND_INCOMPLETE)
    |-> out_word_o.last_of_value)
    else $error("error result without last_of_value");

  a_tag_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_NULL || out_word_o.kind == KIND_BOOL)
    |-> out_word_o.consumed_bytes == 32'd1 && out_word_o.value[63:1] == '0)
    else $error("null or bool result malformed");

  a_double_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind == KIND_DOUBLE |-> out_word_o.consumed_bytes == 32'd9)
    else $error("double result with wrong byte count");

endmodule

bind tagged_value_stream_parser tvsp_checker u_tvsp_checker (.*);
